/* hdl/sre_pkg.sv */
`timescale 1ns / 1ps
// shared types, widths and kernel constants for the rgb sobel edge magnitude block
// no dependencies

package sre_pkg;

    localparam int COLOUR_W    = 10;
    localparam int COLOUR_MAX  = 1023;
    localparam int NUM_ROWS    = 3;
    localparam int NUM_COLOURS = 3;
    localparam int NUM_TAPS    = 9;

    // per colour response stays within +/-6138, folded magnitude within 0..6138
    localparam int SUM_W       = 15;
    localparam int MAG_W       = 13;
    localparam int MAG_MAX     = 6138;
    localparam int TOTAL_W     = 15;

    // floor(t / 3) for t < 4096 as (t * 21846) >> 16
    localparam int DIVISOR     = 3;
    localparam int SAT_LIMIT   = COLOUR_MAX * DIVISOR;
    localparam int QUOT_IN_W   = 12;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP3      = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int PROD_W      = QUOT_IN_W + RECIP_W;

    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 16;

    // taps indexed as 3*col + row, col 0 is the newest column
    localparam int KERNEL_X [0:NUM_TAPS-1] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    localparam int KERNEL_Y [0:NUM_TAPS-1] = '{1, 2, 1, 0, 0, 0, -1, -2, -1};

    typedef logic [COLOUR_W-1:0]  t_pixel;
    typedef t_pixel [NUM_ROWS-1:0] t_trio;   // one colour of one column, row 0 current line
    typedef logic [MAG_W-1:0]     t_mag;

endpackage

/* hdl/sre_colour_mag.sv */
`timescale 1ns / 1ps
// combined sobel x+y response of one colour over a 3x3 window, folded to a magnitude
// depends on sre_pkg

module sre_colour_mag (
    input  sre_pkg::t_trio i_col0,
    input  sre_pkg::t_trio i_col1,
    input  sre_pkg::t_trio i_col2,
    output sre_pkg::t_mag  o_mag
);
    import sre_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] weight;
    logic signed [SUM_W-1:0] pix;
    t_trio                   cols [0:2];

    assign cols[0] = i_col0;
    assign cols[1] = i_col1;
    assign cols[2] = i_col2;

    always_comb begin
        sum    = '0;
        weight = '0;
        pix    = '0;
        for (int t = 0; t < NUM_TAPS; t++) begin
            weight = SUM_W'(KERNEL_X[t] + KERNEL_Y[t]);
            pix    = $signed(SUM_W'(cols[t / NUM_ROWS][t % NUM_ROWS]));
            sum    = sum + weight * pix;
        end
    end

    // large positive sums clamp, negative sums fold without a clamp
    always_comb begin
        if (sum > $signed(SUM_W'(COLOUR_MAX))) begin
            o_mag = MAG_W'(COLOUR_MAX);
        end else if (sum > 0) begin
            o_mag = MAG_W'(sum);
        end else begin
            o_mag = MAG_W'(-sum);
        end
    end

endmodule

/* hdl/sobel_rgb_edge_magnitude.sv */
`timescale 1ns / 1ps
// top level of the rgb sobel edge magnitude block: window history, two-stage pipeline
// depends on sre_pkg and sre_colour_mag
//
// usage:
//   slave channel: one beat is one pixel column, nine 10-bit colour values in tdata
//   (current line, line above, two lines above; red, green, blue each). the block
//   keeps the two previous columns and forms a 3x3 window with each new beat.
//   master channel: one beat per input beat, a 10-bit edge magnitude in tdata.
// timing: 2 register stages; o_m_axis_tvalid rises at the edge after the accepting one.
// throughput: one column per cycle unless stalled; stage 1 computes the three colour
//   magnitudes, stage 2 sums them, divides by three via reciprocal multiply, saturates.
// reset: synchronous active low; both pipeline stages empty, the column history
//   clears to zero pixels so the first two windows see black on the older side.
// stall: when i_m_axis_tready is low the result holds; the pipeline still takes
//   beats until both stages are full, then o_s_axis_tready drops.

module sobel_rgb_edge_magnitude (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // cur_red, cur_green, cur_blue, prev_red, prev_green, prev_blue,
    // older_red, older_green, older_blue, 10 bits each, zero pad [95:90]
    input  logic [sre_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // edge_value [9:0], zero pad [15:10]
    output logic [sre_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import sre_pkg::*;

    t_trio new_col   [NUM_COLOURS];
    t_trio r_hist0   [NUM_COLOURS];
    t_trio r_hist1   [NUM_COLOURS];
    t_mag  mag       [NUM_COLOURS];
    t_mag  r_mag     [NUM_COLOURS];

    logic                 r_a_valid;
    logic                 n_a_valid;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [COLOUR_W-1:0]  r_out_data;
    logic [COLOUR_W-1:0]  n_out_data;
    logic                 out_free;
    logic                 a_free;
    logic                 s_acc;
    logic                 a_adv;
    logic [TOTAL_W-1:0]   total;
    logic [PROD_W-1:0]    prod;

    // unpack the column, field index is 3*row + colour
    always_comb begin
        for (int c = 0; c < NUM_COLOURS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                new_col[c][r] = i_s_axis_tdata[(NUM_COLOURS*r + c)*COLOUR_W +: COLOUR_W];
            end
        end
    end

    genvar gc;
    generate
        for (gc = 0; gc < NUM_COLOURS; gc++) begin : g_colour
            sre_colour_mag u_mag (
                .i_col0 (new_col[gc]),
                .i_col1 (r_hist0[gc]),
                .i_col2 (r_hist1[gc]),
                .o_mag  (mag[gc])
            );
        end
    endgenerate

    // handshake through the two stages
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign a_adv           = r_a_valid && out_free;
    assign a_free          = !r_a_valid || out_free;
    assign o_s_axis_tready = a_free;
    assign s_acc           = i_s_axis_tvalid && a_free;

    always_comb begin
        n_a_valid = r_a_valid;
        if (a_free) begin
            n_a_valid = i_s_axis_tvalid;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = r_a_valid;
        end
    end

    // stage 2: average of the three magnitudes, saturated
    assign total = TOTAL_W'(r_mag[0]) + TOTAL_W'(r_mag[1]) + TOTAL_W'(r_mag[2]);
    assign prod  = PROD_W'(total[QUOT_IN_W-1:0]) * PROD_W'(RECIP3);

    always_comb begin
        if (total >= TOTAL_W'(SAT_LIMIT)) begin
            n_out_data = COLOUR_W'(COLOUR_MAX);
        end else begin
            n_out_data = prod[RECIP_SHIFT +: COLOUR_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_COLOURS; c++) begin
                r_hist0[c] <= '0;
                r_hist1[c] <= '0;
            end
        end else begin
            r_a_valid   <= n_a_valid;
            r_out_valid <= n_out_valid;
            if (s_acc) begin
                for (int c = 0; c < NUM_COLOURS; c++) begin
                    r_hist1[c] <= r_hist0[c];
                    r_hist0[c] <= new_col[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            for (int c = 0; c < NUM_COLOURS; c++) begin
                r_mag[c] <= mag[c];
            end
        end
        if (a_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-COLOUR_W){1'b0}}, r_out_data};

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_a_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    // an accepted beat never lands on a stage that cannot drain
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |-> !(r_a_valid && r_out_valid && !i_m_axis_tready))
        else $error("beat accepted into a full pipeline");

    // stage 1 holds its magnitudes while blocked
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !out_free |=> r_a_valid && $stable(r_mag[0]) && $stable(r_mag[1])
            && $stable(r_mag[2]))
        else $error("stage 1 changed while stalled");

    // folded magnitudes stay in the reachable range
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_mag[0] <= MAG_W'(MAG_MAX)) && (r_mag[1] <= MAG_W'(MAG_MAX))
            && (r_mag[2] <= MAG_W'(MAG_MAX)))
        else $error("colour magnitude out of range");

endmodule
